/* sv/linear_probe_hash_table_defines.svh */
// ---------------------------------------------------------------------------
// linear probe hash table assertion macros
// clocked assertion helpers used by the hash table rtl
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LPHT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LPHT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LPHT_ASSERT(label, prop, msg)
`define LPHT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* sv/lpht_pkg.sv */
// ---------------------------------------------------------------------------
// lpht_pkg
// types and constants of the linear probe hash table
// ---------------------------------------------------------------------------
package lpht_pkg;

   localparam int CAPACITY  = 16;
   localparam int KEY_BYTES = 8;
   localparam int HALF_CAP  = CAPACITY / 2;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;

   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_SET     = 2'd1,
      OP_RESTART = 2'd2,
      OP_NEXT    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_NOT_FOUND = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_ZERO      = 3'd3,
      STAT_END       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_CHECK,
      ST_SCAN,
      ST_FETCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key_bytes;
      logic [3:0]  key_len;
      logic [31:0] data_value;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] found_value;
      logic [63:0] entry_key;
      logic [3:0]  entry_key_len;
      logic        was_new;
      logic [4:0]  entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] key;
      logic [3:0]  key_len;
      logic [31:0] value;
   } slot_type;

   // h * 1099511628211 as shifts and adds
   function automatic logic [63:0] fnv_mult(input logic [63:0] h);
      return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
   endfunction

endpackage

/* sv/lpht_chan_if.sv */
// ---------------------------------------------------------------------------
// lpht_chan_if
// valid/ready channel carrying one word
// ---------------------------------------------------------------------------
interface lpht_chan_if #(
   parameter type word_type = logic
) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* sv/linear_probe_hash_table.sv */
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing hash table, fnv-1a 64 key hash, linear probing
// ---------------------------------------------------------------------------
// channel   dir  word
// req_chan  in   op, key_bytes, key_len, data_value
// rsp_chan  out  status, found_value, entry_key, entry_key_len, was_new,
//                entry_count
//
// one word at a time: an accept state, then hash steps (one fnv step per byte,
// one to pick the start slot), a probe and a check state per probed slot
// through the slot memory read port, then a done state to hand off; next ops
// walk valid bits one slot a cycle.
// synchronous reset clears valid bits, count and iterator at once.
// the response register lets a new word in while the last one is unread.
// ---------------------------------------------------------------------------
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table (
   input  logic        clock,
   input  logic        reset,
   lpht_chan_if.sink   req_chan,
   lpht_chan_if.source rsp_chan
);

   localparam int IDX_W = lpht_pkg::IDX_W;
   localparam int CNT_W = lpht_pkg::CNT_W;

   lpht_pkg::state_type    state_ff, state_in;
   lpht_pkg::op_type       op_ff, op_in;
   logic [63:0]            key_ff, key_in;
   logic [3:0]             len_ff, len_in;
   logic [31:0]            val_ff, val_in;
   logic [63:0]            hash_ff, hash_in;
   logic [3:0]             byte_ff, byte_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0]       probes_ff, probes_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       iter_ff, iter_in;
   logic [lpht_pkg::CAPACITY-1:0] valid_ff, valid_in;
   lpht_pkg::rsp_word_type res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   lpht_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   lpht_pkg::slot_type     mem [lpht_pkg::CAPACITY];
   lpht_pkg::slot_type     rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   lpht_pkg::slot_type     wr_data;

   logic                   accept;
   logic                   hand_off;
   logic [3:0]             req_len;
   logic [63:0]            key_mask;
   logic [63:0]            hash_x;
   logic                   slot_valid;
   logic                   slot_match;

   assign req_chan.ready = (state_ff == lpht_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign hand_off       = (state_ff == lpht_pkg::ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   assign req_len  = (req_chan.data.key_len > 4'(lpht_pkg::KEY_BYTES))
                     ? 4'(lpht_pkg::KEY_BYTES) : req_chan.data.key_len;
   assign key_mask = (req_len >= 4'd8) ? '1 : ((64'd1 << {req_len, 3'b000}) - 64'd1);
   assign hash_x   = hash_ff ^ {56'd0, key_ff[{byte_ff[2:0], 3'b000} +: 8]};

   assign slot_valid = valid_ff[idx_ff];
   assign slot_match = (rd_data_ff.key_len == len_ff) && (rd_data_ff.key == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpht_pkg::ST_IDLE: begin
            if (accept) begin
               if (lpht_pkg::op_type'(req_chan.data.op) == lpht_pkg::OP_RESTART)
                  state_in = lpht_pkg::ST_DONE;
               else if (lpht_pkg::op_type'(req_chan.data.op) == lpht_pkg::OP_NEXT)
                  state_in = lpht_pkg::ST_SCAN;
               else if (lpht_pkg::op_type'(req_chan.data.op) == lpht_pkg::OP_SET &&
                        req_chan.data.data_value == 32'd0)
                  state_in = lpht_pkg::ST_DONE;
               else
                  state_in = lpht_pkg::ST_HASH;
            end
         end
         lpht_pkg::ST_HASH: begin
            if (byte_ff == len_ff) state_in = lpht_pkg::ST_PROBE;
         end
         lpht_pkg::ST_PROBE: state_in = lpht_pkg::ST_CHECK;
         lpht_pkg::ST_CHECK: begin
            if (!slot_valid || slot_match ||
                probes_ff == CNT_W'(lpht_pkg::CAPACITY - 1))
               state_in = lpht_pkg::ST_DONE;
            else
               state_in = lpht_pkg::ST_PROBE;
         end
         lpht_pkg::ST_SCAN: begin
            if (iter_ff == CNT_W'(lpht_pkg::CAPACITY))
               state_in = lpht_pkg::ST_DONE;
            else if (valid_ff[iter_ff[IDX_W-1:0]])
               state_in = lpht_pkg::ST_FETCH;
         end
         lpht_pkg::ST_FETCH: state_in = lpht_pkg::ST_DONE;
         lpht_pkg::ST_DONE: begin
            if (hand_off) state_in = lpht_pkg::ST_IDLE;
         end
         default: state_in = lpht_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      val_in       = val_ff;
      hash_in      = hash_ff;
      byte_in      = byte_ff;
      idx_in       = idx_ff;
      probes_in    = probes_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      valid_in     = valid_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = idx_ff;
      mem_we       = 1'b0;
      wr_data      = '{key: key_ff, key_len: len_ff, value: val_ff};
      case (state_ff)
         lpht_pkg::ST_IDLE: begin
            if (accept) begin
               op_in   = lpht_pkg::op_type'(req_chan.data.op);
               key_in  = req_chan.data.key_bytes & key_mask;
               len_in  = req_len;
               val_in  = req_chan.data.data_value;
               hash_in = lpht_pkg::HASH_BASIS;
               byte_in = 4'd0;
               res_in  = '0;
               if (lpht_pkg::op_type'(req_chan.data.op) == lpht_pkg::OP_RESTART)
                  iter_in = '0;
               if (lpht_pkg::op_type'(req_chan.data.op) == lpht_pkg::OP_SET &&
                   req_chan.data.data_value == 32'd0)
                  res_in.status = lpht_pkg::STAT_ZERO;
            end
         end
         lpht_pkg::ST_HASH: begin
            if (byte_ff == len_ff) begin
               idx_in    = hash_ff[IDX_W-1:0];
               probes_in = '0;
            end else begin
               hash_in = lpht_pkg::fnv_mult(hash_x);
               byte_in = byte_ff + 4'd1;
            end
         end
         lpht_pkg::ST_PROBE: rd_addr = idx_ff;
         lpht_pkg::ST_CHECK: begin
            if (!slot_valid) begin
               if (op_ff == lpht_pkg::OP_GET) begin
                  res_in.status = lpht_pkg::STAT_NOT_FOUND;
               end else if (count_ff >= CNT_W'(lpht_pkg::HALF_CAP)) begin
                  res_in.status = lpht_pkg::STAT_FULL;
               end else begin
                  mem_we           = 1'b1;
                  valid_in[idx_ff] = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
                  res_in.was_new   = 1'b1;
               end
            end else if (slot_match) begin
               if (op_ff == lpht_pkg::OP_GET)
                  res_in.found_value = rd_data_ff.value;
               else
                  mem_we = 1'b1;
            end else if (probes_ff == CNT_W'(lpht_pkg::CAPACITY - 1)) begin
               res_in.status = (op_ff == lpht_pkg::OP_GET)
                               ? lpht_pkg::STAT_NOT_FOUND : lpht_pkg::STAT_FULL;
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               probes_in = probes_ff + CNT_W'(1);
            end
         end
         lpht_pkg::ST_SCAN: begin
            rd_addr = iter_ff[IDX_W-1:0];
            if (iter_ff == CNT_W'(lpht_pkg::CAPACITY))
               res_in.status = lpht_pkg::STAT_END;
            else
               iter_in = iter_ff + CNT_W'(1);
         end
         lpht_pkg::ST_FETCH: begin
            res_in.found_value   = rd_data_ff.value;
            res_in.entry_key     = rd_data_ff.key;
            res_in.entry_key_len = rd_data_ff.key_len;
         end
         lpht_pkg::ST_DONE: begin
            if (hand_off) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = res_ff;
               rsp_data_in.entry_count = 5'(count_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpht_pkg::ST_IDLE;
         count_ff     <= '0;
         iter_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iter_ff      <= iter_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      val_ff      <= val_in;
      hash_ff     <= hash_in;
      byte_ff     <= byte_in;
      idx_ff      <= idx_in;
      probes_ff   <= probes_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   `LPHT_ASSERT(a_count_limit, count_ff <= CNT_W'(lpht_pkg::HALF_CAP), "count above half capacity")
   `LPHT_ASSERT(a_iter_limit, iter_ff <= CNT_W'(lpht_pkg::CAPACITY), "iterator past end")
   `LPHT_ASSERT(a_write_in_check, mem_we |-> state_ff == lpht_pkg::ST_CHECK && op_ff == lpht_pkg::OP_SET, "slot write outside set check")
   `LPHT_ASSERT(a_count_grows, count_ff != $past(count_ff) |-> $past(res_in.was_new), "count changed without insert")
   `LPHT_ASSERT_ALWAYS(a_reset_idle, reset |=> state_ff == lpht_pkg::ST_IDLE && !rsp_valid_ff, "not idle after reset")

endmodule

/* dv/linear_probe_hash_table_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// linear_probe_hash_table_tb
// self-checking bench for the hash table: get, set, restart and next words
// with random gaps and response stalls, checked against a shadow table
// ---------------------------------------------------------------------------
module linear_probe_hash_table_tb;

   localparam logic [63:0] HASH_MULT = 64'd1099511628211;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 880;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpht_chan_if #(.word_type(lpht_pkg::req_word_type)) req_if ();
   lpht_chan_if #(.word_type(lpht_pkg::rsp_word_type)) rsp_if ();

   linear_probe_hash_table DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // table shadow
   logic [63:0] tbl_key   [lpht_pkg::CAPACITY];
   logic [3:0]  tbl_len   [lpht_pkg::CAPACITY];
   logic [31:0] tbl_value [lpht_pkg::CAPACITY];
   logic        tbl_valid [lpht_pkg::CAPACITY];
   int          tbl_count;
   int          iter_pos;

   lpht_pkg::rsp_word_type expected_rsp[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  no_idle     = 0;
   int  hold_request = 0;
   int  hold_left    = 0;
   int  stall_left   = 0;

   // key pool for hits
   logic [63:0] pool_key [12];
   logic [3:0]  pool_len [12];

   function automatic logic [63:0] fnv_hash(logic [63:0] key, int len);
      logic [63:0] h;
      h = lpht_pkg::HASH_BASIS;
      for (int i = 0; i < len; i++) begin
         h = h ^ {56'd0, key[8*i +: 8]};
         h = h * HASH_MULT;
      end
      return h;
   endfunction

   function automatic lpht_pkg::rsp_word_type table_op(lpht_pkg::req_word_type w);
      lpht_pkg::rsp_word_type r;
      int len, idx, slot;
      bit hit, has_empty;
      logic [63:0] key;
      r = '0;
      len = (w.key_len > lpht_pkg::KEY_BYTES) ? lpht_pkg::KEY_BYTES : int'(w.key_len);
      key = (len >= 8) ? w.key_bytes : (w.key_bytes & ((64'd1 << (8 * len)) - 64'd1));
      hit = 0;
      has_empty = 0;
      slot = 0;
      if (w.op == lpht_pkg::OP_GET || w.op == lpht_pkg::OP_SET) begin
         idx = int'(fnv_hash(key, len) % lpht_pkg::CAPACITY);
         for (int n = 0; n < lpht_pkg::CAPACITY; n++) begin
            if (!tbl_valid[idx]) begin
               slot = idx;
               has_empty = 1;
               break;
            end
            if (tbl_len[idx] == len && tbl_key[idx] == key) begin
               slot = idx;
               hit = 1;
               break;
            end
            idx = (idx + 1) % lpht_pkg::CAPACITY;
         end
      end
      case (w.op)
         lpht_pkg::OP_GET: begin
            if (hit) r.found_value = tbl_value[slot];
            else r.status = lpht_pkg::STAT_NOT_FOUND;
         end
         lpht_pkg::OP_SET: begin
            if (w.data_value == 0) r.status = lpht_pkg::STAT_ZERO;
            else if (hit) tbl_value[slot] = w.data_value;
            else if (tbl_count >= lpht_pkg::HALF_CAP || !has_empty)
               r.status = lpht_pkg::STAT_FULL;
            else begin
               tbl_key[slot]   = key;
               tbl_len[slot]   = 4'(len);
               tbl_value[slot] = w.data_value;
               tbl_valid[slot] = 1'b1;
               tbl_count++;
               r.was_new = 1'b1;
            end
         end
         lpht_pkg::OP_RESTART: iter_pos = 0;
         default: begin
            r.status = lpht_pkg::STAT_END;
            while (iter_pos < lpht_pkg::CAPACITY) begin
               idx = iter_pos;
               iter_pos++;
               if (tbl_valid[idx]) begin
                  r.status        = lpht_pkg::STAT_OK;
                  r.found_value   = tbl_value[idx];
                  r.entry_key     = tbl_key[idx];
                  r.entry_key_len = tbl_len[idx];
                  break;
               end
            end
         end
      endcase
      r.entry_count = tbl_count[4:0];
      return r;
   endfunction

   task automatic send_word(lpht_pkg::op_type op, logic [63:0] key, logic [3:0] len,
                            logic [31:0] val);
      lpht_pkg::req_word_type w;
      int gap;
      w.op = op;
      w.key_bytes = key;
      w.key_len = len;
      w.data_value = val;
      gap = no_idle ? 0 : int'($urandom_range(0, 8));
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      do @(posedge clock); while (!req_if.ready);
      expected_rsp.push_back(table_op(w));
   endtask

   // response side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            stall_left = no_idle ? 0 : int'($urandom_range(0, 8));
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // response check
   always @(posedge clock) begin
      lpht_pkg::rsp_word_type exp_w, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (expected_rsp.size() == 0) begin
            $error("response with nothing expected: %h", got);
            error_count++;
         end else begin
            exp_w = expected_rsp.pop_front();
            if (got.status !== exp_w.status) begin
               $error("status: expected %0d, got %0d", exp_w.status, got.status);
               error_count++;
            end
            if (got.found_value !== exp_w.found_value) begin
               $error("found_value: expected %h, got %h", exp_w.found_value, got.found_value);
               error_count++;
            end
            if (got.entry_key !== exp_w.entry_key) begin
               $error("entry_key: expected %h, got %h", exp_w.entry_key, got.entry_key);
               error_count++;
            end
            if (got.entry_key_len !== exp_w.entry_key_len) begin
               $error("entry_key_len: expected %0d, got %0d",
                      exp_w.entry_key_len, got.entry_key_len);
               error_count++;
            end
            if (got.was_new !== exp_w.was_new) begin
               $error("was_new: expected %0d, got %0d", exp_w.was_new, got.was_new);
               error_count++;
            end
            if (got.entry_count !== exp_w.entry_count) begin
               $error("entry_count: expected %0d, got %0d", exp_w.entry_count, got.entry_count);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("linear_probe_hash_table_tb: errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic test_empty_table();
      send_word(lpht_pkg::OP_GET, 64'h1234, 4'd2, 32'd0);
      send_word(lpht_pkg::OP_NEXT, 64'd0, 4'd0, 32'd0);
      send_word(lpht_pkg::OP_NEXT, 64'd0, 4'd0, 32'd0);
      send_word(lpht_pkg::OP_RESTART, 64'd0, 4'd0, 32'd0);
   endtask

   task automatic test_insert_and_lookup();
      send_word(lpht_pkg::OP_SET, '1, 4'd8, 32'd0);
      send_word(lpht_pkg::OP_SET, '1, 4'd8, 32'hFFFF_FFFF);
      send_word(lpht_pkg::OP_GET, '1, 4'd8, 32'd0);
      send_word(lpht_pkg::OP_SET, '1, 4'd8, 32'h0000_0001);
      send_word(lpht_pkg::OP_GET, '1, 4'd8, 32'd0);
   endtask

   task automatic test_key_length_rules();
      send_word(lpht_pkg::OP_SET, 64'hDEAD_BEEF_0000_0000, 4'd0, 32'h0000_0002);
      send_word(lpht_pkg::OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'd0);
      send_word(lpht_pkg::OP_SET, 64'h0123_4567_89AB_CDEF, 4'd15, 32'h5555_AAAA);
      send_word(lpht_pkg::OP_GET, 64'h0123_4567_89AB_CDEF, 4'd8, 32'd0);
      send_word(lpht_pkg::OP_SET, 64'hA5A5_A5A5_A5C0_FFEE, 4'd3, 32'h8000_0000);
      send_word(lpht_pkg::OP_GET, 64'h1111_1111_11C0_FFEE, 4'd3, 32'd0);
      send_word(lpht_pkg::OP_GET, 64'h0000_0000_00C0_FFEE, 4'd2, 32'd0);
   endtask

   task automatic test_iteration();
      send_word(lpht_pkg::OP_RESTART, 64'd0, 4'd0, 32'd0);
      repeat (6) send_word(lpht_pkg::OP_NEXT, 64'd0, 4'd0, 32'd0);
   endtask

   task automatic test_fill_to_capacity();
      for (int i = 0; i < 6; i++)
         send_word(lpht_pkg::OP_SET, pool_key[i], pool_len[i], $urandom() | 32'd1);
      send_word(lpht_pkg::OP_SET, pool_key[0], pool_len[0], 32'h7FFF_FFFF);
   endtask

   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      repeat (20) send_word(lpht_pkg::op_type'($urandom_range(0, 3)),
                            pool_key[$urandom_range(0, 11)],
                            pool_len[$urandom_range(0, 11)], $urandom());
   endtask

   task automatic test_random_mix();
      int k, pick;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] val;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
         k = int'($urandom_range(0, 11));
         if ($urandom_range(0, 4) != 0) begin
            len = pool_len[k];
            key = {$urandom(), $urandom()};
            if (len < 8) key = (key & ~((64'd1 << (8 * len)) - 64'd1))
                              | (pool_key[k] & ((64'd1 << (8 * len)) - 64'd1));
            else key = pool_key[k];
            if (len == 8 && $urandom_range(0, 3) == 0) len = 4'($urandom_range(8, 15));
         end else begin
            key = {$urandom(), $urandom()};
            len = 4'($urandom_range(0, 15));
         end
         val = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom();
         pick = int'($urandom_range(0, 99));
         if (pick < 35) send_word(lpht_pkg::OP_GET, key, len, val);
         else if (pick < 70) send_word(lpht_pkg::OP_SET, key, len, val);
         else if (pick < 80) send_word(lpht_pkg::OP_RESTART, key, len, val);
         else send_word(lpht_pkg::OP_NEXT, key, len, val);
      end
      no_idle = 0;
   endtask

   initial begin
      int wait_cycles;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      for (int i = 0; i < lpht_pkg::CAPACITY; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_key[i]   = '0;
         tbl_len[i]   = '0;
         tbl_value[i] = '0;
      end
      tbl_count = 0;
      iter_pos = 0;
      for (int i = 0; i < 12; i++) begin
         pool_len[i] = 4'(i % 9);
         pool_key[i] = {$urandom(), $urandom()};
         if (pool_len[i] < 8) pool_key[i] &= (64'd1 << (8 * pool_len[i])) - 64'd1;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_insert_and_lookup();
      test_key_length_rules();
      test_iteration();
      test_fill_to_capacity();
      test_backpressure();
      test_random_mix();

      req_if.valid <= 1'b0;
      wait_cycles = 0;
      while (expected_rsp.size() != 0 && wait_cycles < WATCHDOG_LIMIT * 4) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_rsp.size() == 0)
         $display("linear_probe_hash_table_tb: clean");
      else
         $display("linear_probe_hash_table_tb: errors");
      $finish;
   end

endmodule
